### rtl/aidp_pkg.sv
// ---------------------------------------------------------------------------
// aidp_pkg
// Shared types and constants of the archive index decrypt parser: channel
// payloads, byte kind codes, register indexes and register reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aidp_pkg;

   // byte kind codes carried on the result channel
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_NAME    = 2'd1;
   localparam logic [1:0] KIND_OFFSET  = 2'd2;
   localparam logic [1:0] KIND_PAYLOAD = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_COUNT_KEY        = 2'd0;
   localparam logic [1:0] CSR_FIRST_SUBTRAHEND = 2'd1;
   localparam logic [1:0] CSR_XOR_MASK         = 2'd2;
   localparam logic [1:0] CSR_POSITION_BASE    = 2'd3;

   // register reset values
   localparam logic [31:0] COUNT_KEY_RESET        = 32'h3BD7_A59A;
   localparam logic [7:0]  FIRST_SUBTRAHEND_RESET = 8'd39;
   localparam logic [7:0]  XOR_MASK_RESET         = 8'hA5;
   localparam logic [7:0]  POSITION_BASE_RESET    = 8'd27;

   // index entry layout
   localparam logic [4:0] ENTRY_LAST_BYTE = 5'd16;
   localparam logic [4:0] NAME_BYTES      = 5'd13;
   localparam logic [2:0] HEADER_BYTES    = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  byte_kind;
      logic [7:0]  plain_byte;
      logic [31:0] entry_number;
      logic [4:0]  place_in_entry;
      logic        entry_done;
      logic [31:0] entry_offset;
      logic        length_valid;
      logic [31:0] previous_length;
      logic        count_valid;
      logic [31:0] entry_count;
   } rsp_payload_type;

endpackage

### rtl/aidp_if.sv
// ---------------------------------------------------------------------------
// aidp_req_if / aidp_rsp_if
// Valid/ready channels of the archive index decrypt parser: raw archive
// bytes in, classified and decrypted bytes out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aidp_req_if;
   import aidp_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface aidp_rsp_if;
   import aidp_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/archive_index_decrypt_parser.sv
// ---------------------------------------------------------------------------
// archive_index_decrypt_parser
// Sorts archive bytes into count header, encrypted index entries and payload,
// decrypts index bytes and reports each entry's offset and the previous
// entry's length.
// ---------------------------------------------------------------------------
// channel   | side  | item
// ----------+-------+--------------------------------------------------
// req_if    | sink  | data_byte, restart
// rsp_if    | source| kind, plain byte, entry info, offset, length, count
// csr_*     | write | count_key, first_subtrahend, xor_mask, position_base
//
// One item per cycle sustained while results are taken; an item sits in the input
// register after the edge that accepts it and moves on to the result register.
// The parse state updates as an item moves from input to result register.
// A stalled result keeps its register; one more item waits in the input
// register before req_if.ready drops.
// Synchronous reset restores the register defaults and clears parse state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module archive_index_decrypt_parser (
   input  logic        clock,
   input  logic        reset,
   aidp_req_if.sink    req_if,
   aidp_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import aidp_pkg::*;

   // configuration registers
   logic [31:0] count_key_ff;
   logic [7:0]  first_sub_ff;
   logic [7:0]  xor_mask_ff;
   logic [7:0]  pos_base_ff;

   // input stage
   logic            stage_valid_ff;
   req_payload_type stage_ff;

   // parse state
   logic [2:0]  hdr_seen_ff,  hdr_seen_in;
   logic [31:0] count_ff,     count_in;
   logic [31:0] entries_ff,   entries_in;
   logic [4:0]  bie_ff,       bie_in;
   logic [7:0]  pos_ff,       pos_in;
   logic [31:0] gather_ff,    gather_in;
   logic [31:0] last_off_ff,  last_off_in;
   logic        have_last_ff, have_last_in;

   // result stage
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   // working values with restart applied
   logic [2:0]  hdr_eff;
   logic [31:0] count_eff;
   logic [31:0] entries_eff;
   logic [4:0]  bie_eff;
   logic [7:0]  pos_eff;
   logic [31:0] gather_eff;
   logic [31:0] last_off_eff;
   logic        have_last_eff;
   logic [7:0]  raw;
   logic [7:0]  dec_sub;
   logic [7:0]  dec_xor;
   logic [7:0]  dec_pos;
   logic [7:0]  dec_byte;
   logic [4:0]  off_sel;
   logic [31:0] gather_new;

   logic advance;

   // handshake: the input register refills whenever it moves on
   assign advance      = stage_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !stage_valid_ff || advance;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_key_ff <= COUNT_KEY_RESET;
         first_sub_ff <= FIRST_SUBTRAHEND_RESET;
         xor_mask_ff  <= XOR_MASK_RESET;
         pos_base_ff  <= POSITION_BASE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COUNT_KEY:        count_key_ff <= csr_data;
            CSR_FIRST_SUBTRAHEND: first_sub_ff <= csr_data[7:0];
            CSR_XOR_MASK:         xor_mask_ff  <= csr_data[7:0];
            CSR_POSITION_BASE:    pos_base_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // decryption of one index byte
   always_comb begin
      raw      = stage_ff.data_byte;
      dec_sub  = raw - first_sub_ff;
      dec_xor  = dec_sub ^ xor_mask_ff;
      dec_pos  = pos_base_ff + pos_eff;
      dec_byte = dec_xor - dec_pos;
   end

   // parse step for the item in the input register
   always_comb begin
      // restart clears parse state before the byte is handled
      hdr_eff       = stage_ff.restart ? 3'd0  : hdr_seen_ff;
      count_eff     = stage_ff.restart ? 32'd0 : count_ff;
      entries_eff   = stage_ff.restart ? 32'd0 : entries_ff;
      bie_eff       = stage_ff.restart ? 5'd0  : bie_ff;
      pos_eff       = stage_ff.restart ? 8'd0  : pos_ff;
      gather_eff    = stage_ff.restart ? 32'd0 : gather_ff;
      last_off_eff  = stage_ff.restart ? 32'd0 : last_off_ff;
      have_last_eff = stage_ff.restart ? 1'b0  : have_last_ff;

      hdr_seen_in  = hdr_eff;
      count_in     = count_eff;
      entries_in   = entries_eff;
      bie_in       = bie_eff;
      pos_in       = pos_eff;
      gather_in    = gather_eff;
      last_off_in  = last_off_eff;
      have_last_in = have_last_eff;

      off_sel    = bie_eff - NAME_BYTES;
      gather_new = gather_eff | ({24'd0, dec_byte} << {off_sel[1:0], 3'b000});

      rsp_in = '0;
      rsp_in.plain_byte = raw;

      if (hdr_eff < HEADER_BYTES) begin
         // count header byte, little-endian
         rsp_in.byte_kind = KIND_HEADER;
         count_in    = count_eff | ({24'd0, raw} << {hdr_eff[1:0], 3'b000});
         hdr_seen_in = hdr_eff + 3'd1;
         if (hdr_eff == HEADER_BYTES - 3'd1) begin
            count_in = count_in ^ count_key_ff;
         end
      end else if (entries_eff < count_eff) begin
         // encrypted index byte
         rsp_in.plain_byte     = dec_byte;
         rsp_in.entry_number   = entries_eff;
         rsp_in.place_in_entry = bie_eff;
         pos_in = pos_eff + 8'd1;
         if (bie_eff < NAME_BYTES) begin
            rsp_in.byte_kind = KIND_NAME;
         end else begin
            rsp_in.byte_kind = KIND_OFFSET;
            gather_in = gather_new;
         end
         if (bie_eff == ENTRY_LAST_BYTE) begin
            rsp_in.entry_done   = 1'b1;
            rsp_in.entry_offset = gather_new;
            if (have_last_eff) begin
               rsp_in.length_valid    = 1'b1;
               rsp_in.previous_length = gather_new - last_off_eff - 32'd1;
            end
            last_off_in  = gather_new;
            have_last_in = 1'b1;
            gather_in    = 32'd0;
            bie_in       = 5'd0;
            entries_in   = entries_eff + 32'd1;
         end else begin
            bie_in = bie_eff + 5'd1;
         end
      end else begin
         // payload passes through
         rsp_in.byte_kind    = KIND_PAYLOAD;
         rsp_in.entry_number = count_eff;
      end

      rsp_in.count_valid = (hdr_seen_in >= HEADER_BYTES);
      rsp_in.entry_count = rsp_in.count_valid ? count_in : 32'd0;
   end

   // input register, parse state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hdr_seen_ff    <= 3'd0;
         count_ff       <= 32'd0;
         entries_ff     <= 32'd0;
         bie_ff         <= 5'd0;
         pos_ff         <= 8'd0;
         gather_ff      <= 32'd0;
         last_off_ff    <= 32'd0;
         have_last_ff   <= 1'b0;
      end else begin
         if (req_if.ready) begin
            stage_valid_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            hdr_seen_ff  <= hdr_seen_in;
            count_ff     <= count_in;
            entries_ff   <= entries_in;
            bie_ff       <= bie_in;
            pos_ff       <= pos_in;
            gather_ff    <= gather_in;
            last_off_ff  <= last_off_in;
            have_last_ff <= have_last_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         stage_ff <= req_if.payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // header counter never runs past the header length
   a_hdr_range: assert property (@(posedge clock) disable iff (reset)
      hdr_seen_ff <= HEADER_BYTES)
      else $error("header byte counter out of range");

   // entry byte position stays inside one entry
   a_bie_range: assert property (@(posedge clock) disable iff (reset)
      bie_ff <= ENTRY_LAST_BYTE)
      else $error("entry byte position out of range");

   // a completed entry leaves an offset to measure the next one against
   a_last_kept: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_in.entry_done) |=> have_last_ff)
      else $error("completed entry offset not kept");

   // a length only comes with a completed offset byte
   a_len_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.length_valid) |->
         (rsp_ff.entry_done && rsp_ff.byte_kind == KIND_OFFSET))
      else $error("length reported without a completed entry");

   // both stages full with a stalled result blocks new items
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("item taken while both stages are full");
`endif

endmodule
